### src/mle_pkg.sv
// ----------------------------------------------------------------------------
// mle_pkg
// Shared types and constants for the median / Laplacian edge mask pipeline.
// ----------------------------------------------------------------------------
package mle_pkg;

  localparam int PIX_W   = 17;
  localparam int THR_W   = 20;
  localparam int DIM_W   = 12;
  localparam int POS_W   = 11;
  localparam int PROD_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam logic [PIX_W-1:0] ONE_FX = 17'd65536;
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;
  localparam logic [32:0] LUMA_ROUND = 33'd32768;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd2;

  localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 20'd6554;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 12'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 12'd480;

  typedef logic [PIX_W-1:0] pix_t;
  // index = row * 3 + column, row 0 oldest line, column 2 newest pixel
  typedef pix_t [8:0] win_t;

endpackage

### src/mle_window.sv
// ----------------------------------------------------------------------------
// mle_window
// Two-row line store with a 3x3 window; forwards a same-column write.
// ----------------------------------------------------------------------------
module mle_window #(
  parameter int MAX_WIDTH = mle_pkg::DEF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           rd_valid_i,
  input  logic [CW-1:0]  rd_col_i,
  input  logic           wr_valid_i,
  input  logic [CW-1:0]  wr_col_i,
  input  mle_pkg::pix_t  pix_i,
  input  logic           pix_vld_i,
  output mle_pkg::win_t  win_o,
  output logic           ctr_vld_o
);
  import mle_pkg::*;

  localparam int MW = 2 * PIX_W + 1;

  logic [MW-1:0] mem [MAX_WIDTH];
  logic [MW-1:0] rd_q, fwd_q, word, wr_word;
  logic          hit_q;
  win_t          win_q;
  logic [1:0]    wv_q;
  pix_t          t0, t1;
  logic          t1v;

  assign word    = hit_q ? fwd_q : rd_q;
  assign t0      = word[MW-1 -: PIX_W];
  assign t1      = word[PIX_W:1];
  assign t1v     = word[0];
  assign wr_word = {t1, pix_i, pix_vld_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q  <= mem[rd_col_i];
      fwd_q <= wr_word;
      if (wr_valid_i) begin
        mem[wr_col_i] <= wr_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      win_q <= '0;
      wv_q  <= '0;
    end else if (en_i) begin
      hit_q <= rd_valid_i && wr_valid_i && (rd_col_i == wr_col_i);
      if (wr_valid_i) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= t0;
        win_q[5] <= t1;
        win_q[8] <= pix_i;
        wv_q     <= {t1v, wv_q[1]};
      end
    end
  end

  assign win_o     = win_q;
  assign ctr_vld_o = wv_q[0];

endmodule

### src/mle_median.sv
// ----------------------------------------------------------------------------
// mle_median
// Three-stage 3x3 median: row sort, column selects, final median of three.
// ----------------------------------------------------------------------------
module mle_median (
  input  logic          clk_i,
  input  logic          en_i,
  input  mle_pkg::win_t win_i,
  output mle_pkg::pix_t med_o
);
  import mle_pkg::*;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t lo_q [3];
  pix_t mi_q [3];
  pix_t hi_q [3];
  pix_t a_q, b_q, c_q, med_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        lo_q[r] <= min2(min2(win_i[r*3], win_i[r*3+1]), win_i[r*3+2]);
        mi_q[r] <= med3(win_i[r*3], win_i[r*3+1], win_i[r*3+2]);
        hi_q[r] <= max2(max2(win_i[r*3], win_i[r*3+1]), win_i[r*3+2]);
      end
      a_q   <= max2(max2(lo_q[0], lo_q[1]), lo_q[2]);
      b_q   <= med3(mi_q[0], mi_q[1], mi_q[2]);
      c_q   <= min2(min2(hi_q[0], hi_q[1]), hi_q[2]);
      med_q <= med3(a_q, b_q, c_q);
    end
  end

  assign med_o = med_q;

endmodule

### src/mle_laplace.sv
// ----------------------------------------------------------------------------
// mle_laplace
// 8-neighbour Laplacian: registered partial sums, then magnitude compare.
// ----------------------------------------------------------------------------
module mle_laplace (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  mle_pkg::win_t             win_i,
  input  logic [mle_pkg::THR_W-1:0] thr_i,
  output logic                      edge_o
);
  import mle_pkg::*;

  logic [PIX_W+2:0] c8_q, sa_q, sb_q;
  logic [PIX_W+3:0] d, mag;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c8_q <= {win_i[4], 3'b000};
      sa_q <= 20'(win_i[0]) + 20'(win_i[1]) + 20'(win_i[2]) + 20'(win_i[3]);
      sb_q <= 20'(win_i[5]) + 20'(win_i[6]) + 20'(win_i[7]) + 20'(win_i[8]);
    end
  end

  assign d      = {1'b0, c8_q} - ({1'b0, sa_q} + {1'b0, sb_q});
  assign mag    = d[PIX_W+3] ? (~d + 21'd1) : d;
  assign edge_o = mag >= {1'b0, thr_i};

endmodule

### src/median_laplacian_edge_mask.sv
// Latency: a pixel's result reaches the output register after the
// transaction that completes its neighborhood, i.e. 2*frame_width+2 items on.
// Throughput: one transaction per cycle; the whole pipeline holds on output stall.
// Reset clears control, counters and window registers; data registers and line stores
// are not cleared, and a fill counter masks the unwritten line store entries.
// ----------------------------------------------------------------------------
// median_laplacian_edge_mask
// Luma, 3x3 median, then 8-neighbour Laplacian threshold edge flag; borders flag as edges.
// ----------------------------------------------------------------------------
module median_laplacian_edge_mask #(
  parameter int MAX_WIDTH  = mle_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mle_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mle_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mle_pkg::THR_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mle_pkg::PIX_W-1:0]     red_i,
  input  logic [mle_pkg::PIX_W-1:0]     green_i,
  input  logic [mle_pkg::PIX_W-1:0]     blue_i,
  input  logic                          flush_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mle_pkg::POS_W-1:0]     pixel_x_o,
  output logic [mle_pkg::POS_W-1:0]     pixel_y_o,
  output logic                          is_edge_o,
  output logic                          frame_end_o
);
  import mle_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int HH  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int FCW = $clog2(MAX_WIDTH + 2);

  logic [THR_W-1:0] thr_q;
  logic [DIM_W-1:0] fw_q, fh_q;
  logic [WW-1:0]    w;
  logic [HH-1:0]    h;
  logic [CW-1:0]    wm1;
  logic [RW-1:0]    hm1;
  logic             en, acc;

  // stage registers
  logic             v1_q, real1_q, fill1_q;
  pix_t             r1_q, g1_q, b1_q;
  logic [CW-1:0]    col1_q;
  logic             v2_q, real2_q, fill2_q;
  logic [PROD_W-1:0] pr2_q, pg2_q, pb2_q;
  logic [CW-1:0]    col2_q;
  logic             v3_q, fill3_q;
  logic [CW-1:0]    col3_q;
  logic             v4_q [3];
  logic             vm4_q [3];
  logic             bd4_q [3];
  logic             fl4_q [3];
  pix_t             ct4_q [3];
  logic [CW-1:0]    col4_q [3];
  logic             v7_q, fill7_q;
  logic             v8_q, ve8_q, bd8_q, fe8_q;
  logic [CW-1:0]    x8_q;
  logic [RW-1:0]    y8_q;
  logic             out_valid_q, edge_q, fend_q;
  logic [POS_W-1:0] px_q, py_q;

  logic [CW-1:0]    in_col_q, mid_x_q, out_x_q;
  logic [RW-1:0]    mid_y_q, out_y_q;
  logic [FCW-1:0]   cnt_q;

  logic [CW-1:0]    c_cur, c_nxt;
  logic             fill_cur;
  pix_t             rc, gc, bc, gray, med, f;
  win_t             gwin, fwin;
  logic             gcv, fcv, vm3, ve7, bd3, bd7, fe7, lap_edge;

  assign en          = !out_valid_q || out_ready_i;
  assign acc         = en && in_valid_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  assign w   = (fw_q == '0) ? WW'(1) :
               (32'(fw_q) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_q);
  assign h   = (fh_q == '0) ? HH'(1) :
               (32'(fh_q) > 32'(MAX_HEIGHT)) ? HH'(MAX_HEIGHT) : HH'(fh_q);
  assign wm1 = CW'(32'(w) - 32'd1);
  assign hm1 = RW'(32'(h) - 32'd1);

  assign c_cur    = (32'(in_col_q) >= 32'(w)) ? '0 : in_col_q;
  assign c_nxt    = (32'(c_cur) + 32'd1 >= 32'(w)) ? '0 : CW'(32'(c_cur) + 32'd1);
  assign fill_cur = 32'(cnt_q) >= 32'(w) + 32'd1;

  assign rc   = (r1_q > ONE_FX) ? ONE_FX : r1_q;
  assign gc   = (g1_q > ONE_FX) ? ONE_FX : g1_q;
  assign bc   = (b1_q > ONE_FX) ? ONE_FX : b1_q;
  // drain transactions carry gray zero
  assign gray = real2_q ?
                PIX_W'((33'(pr2_q) + 33'(pg2_q) + 33'(pb2_q) + LUMA_ROUND) >> 16) : '0;

  assign vm3 = fill3_q && gcv;
  assign bd3 = (mid_x_q == '0) || (mid_x_q == wm1) || (mid_y_q == '0) || (mid_y_q == hm1);
  assign f   = (vm4_q[2] && !bd4_q[2]) ? med : ct4_q[2];

  assign ve7 = fill7_q && fcv;
  assign bd7 = (out_x_q == '0) || (out_x_q == wm1) || (out_y_q == '0) || (out_y_q == hm1);
  assign fe7 = (out_x_q == wm1) && (out_y_q == hm1);

  mle_window #(.MAX_WIDTH(MAX_WIDTH)) u_gray_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .rd_valid_i (v1_q),
    .rd_col_i   (col1_q),
    .wr_valid_i (v2_q),
    .wr_col_i   (col2_q),
    .pix_i      (gray),
    .pix_vld_i  (real2_q),
    .win_o      (gwin),
    .ctr_vld_o  (gcv)
  );

  mle_median u_median (
    .clk_i (clk_i),
    .en_i  (en),
    .win_i (gwin),
    .med_o (med)
  );

  mle_window #(.MAX_WIDTH(MAX_WIDTH)) u_filt_win (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .rd_valid_i (v4_q[1]),
    .rd_col_i   (col4_q[1]),
    .wr_valid_i (v4_q[2]),
    .wr_col_i   (col4_q[2]),
    .pix_i      (f),
    .pix_vld_i  (vm4_q[2]),
    .win_o      (fwin),
    .ctr_vld_o  (fcv)
  );

  mle_laplace u_laplace (
    .clk_i  (clk_i),
    .en_i   (en),
    .win_i  (fwin),
    .thr_i  (thr_q),
    .edge_o (lap_edge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= RST_EDGE_THRESHOLD;
      fw_q        <= RST_FRAME_WIDTH;
      fh_q        <= RST_FRAME_HEIGHT;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= '{default: 1'b0};
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
      in_col_q    <= '0;
      mid_x_q     <= '0;
      mid_y_q     <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_EDGE_THRESHOLD: thr_q <= cfg_data_i;
          CFG_FRAME_WIDTH:    fw_q  <= cfg_data_i[DIM_W-1:0];
          CFG_FRAME_HEIGHT:   fh_q  <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      // a new line length restarts the fill count
      if (cfg_valid_i && (cfg_index_i == CFG_FRAME_WIDTH)) begin
        cnt_q <= '0;
      end else if (acc && (32'(cnt_q) < MAX_WIDTH + 1)) begin
        cnt_q <= FCW'(32'(cnt_q) + 32'd1);
      end
      if (en) begin
        v1_q        <= in_valid_i;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        v4_q[0]     <= v3_q;
        v4_q[1]     <= v4_q[0];
        v4_q[2]     <= v4_q[1];
        v7_q        <= v4_q[2];
        v8_q        <= v7_q;
        out_valid_q <= v8_q && ve8_q;
        if (acc) begin
          in_col_q <= c_nxt;
        end
        if (v3_q && vm3) begin
          if (32'(mid_x_q) + 32'd1 >= 32'(w)) begin
            mid_x_q <= '0;
            mid_y_q <= (32'(mid_y_q) + 32'd1 >= 32'(h)) ? '0 : RW'(32'(mid_y_q) + 32'd1);
          end else begin
            mid_x_q <= CW'(32'(mid_x_q) + 32'd1);
          end
        end
        if (v7_q && ve7) begin
          if (32'(out_x_q) + 32'd1 >= 32'(w)) begin
            out_x_q <= '0;
            out_y_q <= (32'(out_y_q) + 32'd1 >= 32'(h)) ? '0 : RW'(32'(out_y_q) + 32'd1);
          end else begin
            out_x_q <= CW'(32'(out_x_q) + 32'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q    <= red_i;
      g1_q    <= green_i;
      b1_q    <= blue_i;
      real1_q <= !flush_i;
      col1_q  <= c_cur;
      fill1_q <= fill_cur;

      pr2_q   <= PROD_W'(rc) * PROD_W'(W_RED);
      pg2_q   <= PROD_W'(gc) * PROD_W'(W_GREEN);
      pb2_q   <= PROD_W'(bc) * PROD_W'(W_BLUE);
      real2_q <= real1_q;
      col2_q  <= col1_q;
      fill2_q <= fill1_q;

      col3_q  <= col2_q;
      fill3_q <= fill2_q;

      vm4_q[0]  <= vm3;
      bd4_q[0]  <= bd3;
      fl4_q[0]  <= fill3_q;
      ct4_q[0]  <= gwin[4];
      col4_q[0] <= col3_q;
      for (int k = 1; k < 3; k++) begin
        vm4_q[k]  <= vm4_q[k-1];
        bd4_q[k]  <= bd4_q[k-1];
        fl4_q[k]  <= fl4_q[k-1];
        ct4_q[k]  <= ct4_q[k-1];
        col4_q[k] <= col4_q[k-1];
      end

      fill7_q <= fl4_q[2];

      ve8_q <= ve7;
      bd8_q <= bd7;
      fe8_q <= fe7;
      x8_q  <= out_x_q;
      y8_q  <= out_y_q;

      px_q   <= POS_W'(x8_q);
      py_q   <= POS_W'(y8_q);
      edge_q <= bd8_q || lap_edge;
      fend_q <= fe8_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign is_edge_o   = edge_q;
  assign frame_end_o = fend_q;

endmodule
